FILE: src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, status codes and helpers for the fixed block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

    localparam int IDX_W          = 6;   // block index width
    localparam int CNT_W          = 7;   // count / watermark width
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int IN_DATA_W      = 8;   // block_index padded to bytes
    localparam int OUT_DATA_W     = 16;  // status, granted_index, free_count

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    // Clamp a block count write into 1..top.
    function automatic logic [CNT_W-1:0] limit_count(input logic [CNT_W-1:0] v,
                                                     input logic [CNT_W-1:0] top);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (v > top) begin
            r = top;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Equal-size block pool with a LIFO free list held in a link memory.
// ----------------------------------------------------------------------------
// The block hands out block indices from a pool of block_count blocks. An
// alloc request (tuser = 0) returns the most recently freed block, or, when
// the free list is empty, the lowest block never handed out (a watermark
// counting upward); with nothing left it reports status EMPTY. A free request
// (tuser = 1) pushes tdata[5:0] onto the head of the free list; an index at
// or above block_count, or a free with nothing allocated, reports status
// BADFREE and changes nothing. Double frees are not detected. Every result
// carries the free count after the request. Writing the config channel sets
// block_count (clamped to 1..min(MAX_BLOCKS,64)) and returns the pool to its
// initial state; write it only while no request is in flight. Timing: the
// result of a request is registered in the output register. The next request
// is taken in a cycle where the output register is empty or its result is
// accepted at the same edge, so requests can follow one per cycle while
// nothing stalls. An alloc that takes a block from a free list holding more
// than one entry holds the input while the S_POP state loads the new head,
// because the link of the head entry comes out of the registered read of
// the single-port link memory. A result stalled by m_axis_tready holds the
// input until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,

    // config: block_count
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CNT_W-1:0]       i_cfg_data,

    // request items
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [IN_DATA_W-1:0]   s_axis_tdata,   // [5:0] block_index, [7:6] zero
    input  wire  [0:0]             s_axis_tuser,   // [0] req_type

    // result items
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata    // [1:0] status, [7:2] granted_index,
                                                   // [14:8] free_count, [15] zero
);

    localparam int DEPTH = (MAX_BLOCKS < 64) ? MAX_BLOCKS : 64;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] TOP = CNT_W'(DEPTH);

    typedef enum logic {S_IDLE, S_POP} t_state;

    // link memory
    logic [IDX_W-1:0] mem_link [DEPTH];
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [IDX_W-1:0] mem_wdata;
    logic [IDX_W-1:0] r_rd_data;

    // state
    t_state           r_state,     n_state;
    logic [IDX_W-1:0] r_head,      n_head;
    logic             r_nonempty,  n_nonempty;
    logic [CNT_W-1:0] r_watermark, n_watermark;
    logic [CNT_W-1:0] r_used,      n_used;
    logic [CNT_W-1:0] r_blk_cnt;
    logic             r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic             in_acc;
    logic             cfg_acc;
    logic [IDX_W-1:0] req_idx;
    logic [CNT_W-1:0] list_len;
    t_status          res_status;
    logic [IDX_W-1:0] res_grant;

    assign req_idx       = s_axis_tdata[IDX_W-1:0];
    assign list_len      = r_watermark - r_used;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_nonempty  = r_nonempty;
        n_watermark = r_watermark;
        n_used      = r_used;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = r_head[AW-1:0];
        mem_wdata   = r_nonempty ? r_head : '0;
        res_status  = ST_OK;
        res_grant   = '0;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_req'(s_axis_tuser[0]))
                        REQ_ALLOC: begin
                            if (r_nonempty) begin
                                res_grant = r_head;
                                n_used    = r_used + 1'b1;
                                if (list_len > CNT_W'(1)) begin
                                    // fetch link of the head, update head next cycle
                                    mem_re  = 1'b1;
                                    n_state = S_POP;
                                end else begin
                                    n_nonempty = 1'b0;
                                    n_head     = '0;
                                end
                            end else if (r_watermark < r_blk_cnt) begin
                                res_grant   = r_watermark[IDX_W-1:0];
                                n_watermark = r_watermark + 1'b1;
                                n_used      = r_used + 1'b1;
                            end else begin
                                res_status = ST_EMPTY;
                            end
                        end
                        REQ_FREE: begin
                            if ({1'b0, req_idx} >= r_blk_cnt || r_used == '0) begin
                                res_status = ST_BADFREE;
                            end else begin
                                mem_we     = 1'b1;
                                mem_addr   = req_idx[AW-1:0];
                                n_head     = req_idx;
                                n_nonempty = 1'b1;
                                n_used     = r_used - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_blk_cnt - n_used, res_grant, res_status};
                end
            end
            S_POP: begin
                n_head  = r_rd_data;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // re-initialise the pool on a block_count write
        if (cfg_acc) begin
            n_state     = S_IDLE;
            n_head      = '0;
            n_nonempty  = 1'b0;
            n_watermark = '0;
            n_used      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_watermark <= '0;
            r_used      <= '0;
            r_blk_cnt   <= limit_count(BLOCK_COUNT_RST, TOP);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_nonempty  <= n_nonempty;
            r_watermark <= n_watermark;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (cfg_acc) begin
                r_blk_cnt <= limit_count(i_cfg_data, TOP);
            end
        end
        r_out_data <= n_out_data;
    end

    // single-port link memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_link[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem_link[mem_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/fbpa_checker.sv
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks for the fixed block pool allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_checker
    import fbpa_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire [OUT_DATA_W-1:0]  m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // status is one of the three codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_EMPTY ||
                           m_axis_tdata[1:0] == ST_BADFREE))
        else $error("bad status code");

    // failed request grants nothing
    a_fail_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[7:2] == '0)
        else $error("granted index on failed request");

    // empty pool means no free blocks
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_EMPTY |-> m_axis_tdata[14:8] == '0)
        else $error("empty reported with free blocks left");

    // free count within the pool size, pad bit zero
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:8] <= 7'd64 && m_axis_tdata[15] == 1'b0)
        else $error("free count out of range");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
